// File: design/local_extrema_detector_macros.svh
// Assertion macros for the local extrema detector.
// Included by the top level; no other dependencies.
`ifndef LOCAL_EXTREMA_DETECTOR_MACROS_SVH
`define LOCAL_EXTREMA_DETECTOR_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define LED_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define LED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/led_pkg.sv
// Shared types and constants for the local extrema detector.
// No dependencies; used by led_queue and local_extrema_detector.
package led_pkg;

   localparam int MAX_LEN      = 65536;
   localparam int SAMPLE_WIDTH = 32;
   localparam int COUNT_WIDTH  = $clog2(MAX_LEN + 1);
   localparam int POS_WIDTH    = 16;
   localparam int TOTAL_WIDTH  = 17;
   localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = {TOTAL_WIDTH{1'b1}};

   // result queue geometry: up to three results per item
   localparam int PUSH_MAX     = 3;
   localparam int PUSH_WIDTH   = $clog2(PUSH_MAX + 1);
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int LEVEL_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_MIN     = 2'd0,
      KIND_MAX     = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                 kind;
      logic [POS_WIDTH-1:0]     position;
      logic [TOTAL_WIDTH-1:0]   minima_total;
      logic [TOTAL_WIDTH-1:0]   maxima_total;
      logic                     too_long;
      logic                     last_of_run;
   } result_type;

   typedef struct packed {
      logic [LEVEL_WIDTH-1:0] level;
      logic                   has_room;
   } queue_status_type;

endpackage

// File: design/led_queue.sv
// Small result queue for the local extrema detector: takes up to three
// results at once and drains one per ready cycle. Depends on led_pkg.
module led_queue (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic [led_pkg::PUSH_WIDTH-1:0]            push_count,
   input  led_pkg::result_type [led_pkg::PUSH_MAX-1:0] push_data,
   output led_pkg::queue_status_type                 status,
   output logic                                      pop_valid,
   input  logic                                      pop_ready,
   output led_pkg::result_type                       pop_data
);
   import led_pkg::*;

   result_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [LEVEL_WIDTH-1:0] level_ff, level_in;
   logic                   pop;

   // present the head entry
   assign pop_valid = (level_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign pop       = pop_valid && pop_ready;

   // room for a full burst of results
   assign status = '{level:    level_ff,
                     has_room: (level_ff <= LEVEL_WIDTH'(QUEUE_DEPTH - PUSH_MAX))};

   // advance pointers and level
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_WIDTH'(push_count);
      rd_ptr_in = rd_ptr_ff + QPTR_WIDTH'(pop);
      level_in  = level_ff + LEVEL_WIDTH'(push_count) - LEVEL_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // write the pushed results behind the tail
   always_ff @(posedge clock) begin
      for (int i = 0; i < PUSH_MAX; i++) begin
         if (PUSH_WIDTH'(i) < push_count) begin
            entry_ff[wr_ptr_ff + QPTR_WIDTH'(i)] <= push_data[i];
         end
      end
   end

endmodule

// File: design/local_extrema_detector.sv
// Top level of the local extrema detector: sample window, decisions and counts.
// Depends on led_pkg, led_queue and local_extrema_detector_macros.svh.
//
// Usage:
//   req_ channel carries one signed sample per item with req_final_sample
//   marking the last sample of an array. rsp_ channel carries results:
//   kind 0/1 for a strict local minimum/maximum at rsp_position, kind 2
//   for the end-of-array summary with both totals and the too_long flag.
//   rsp_last_of_run marks the last result caused by one input item.
//   An accepted item's results are registered into the result queue and
//   offered from its head. Throughput: one item per cycle while req_ready is
//   high; every item decides at most one position except a final one, which
//   yields up to three results that leave the four-entry queue one per cycle
//   while rsp_ready is high. req_ready is high while the queue holds at most
//   one result, so a stalled receiver backs up into the queue and then holds
//   off the source; no result is dropped. A final sample returns the window
//   and all counts to their reset state for the next array.
//   Reset empties the queue and clears the window and counts.
`include "local_extrema_detector_macros.svh"

module local_extrema_detector (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_sample,
   input  logic        req_final_sample,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_position,
   output logic [16:0] rsp_minima_total,
   output logic [16:0] rsp_maxima_total,
   output logic        rsp_too_long,
   output logic        rsp_last_of_run
);
   import led_pkg::*;

   logic signed [SAMPLE_WIDTH-1:0] older_ff, older_in;
   logic signed [SAMPLE_WIDTH-1:0] newer_ff, newer_in;
   logic [COUNT_WIDTH-1:0]         count_ff, count_in;
   logic [TOTAL_WIDTH-1:0]         minima_ff, minima_in;
   logic [TOTAL_WIDTH-1:0]         maxima_ff, maxima_in;
   logic                           overflow_ff, overflow_in;

   logic signed [SAMPLE_WIDTH-1:0] x;
   logic                           accept;
   logic                           in_range, has_left;
   logic                           d1_en, d1_lt, d1_gt;
   logic                           d2_en, d2_lt, d2_gt;
   logic                           min_inc, max_inc;
   logic [PUSH_WIDTH-1:0]          slot;
   result_type [PUSH_MAX-1:0]      push_data;
   result_type                     head;
   queue_status_type               q_status;

   assign x         = signed'(req_sample[SAMPLE_WIDTH-1:0]);
   assign req_ready = q_status.has_room;
   assign accept    = req_valid && req_ready;

   // window tests for the position left of x and, on a final sample, for x
   always_comb begin
      in_range = (count_ff < COUNT_WIDTH'(MAX_LEN));
      has_left = (count_ff >= COUNT_WIDTH'(2));
      d1_en    = in_range ? (count_ff != '0) : !overflow_ff;
      d1_lt    = (!has_left || (newer_ff < older_ff)) && (newer_ff < x);
      d1_gt    = (!has_left || (newer_ff > older_ff)) && (newer_ff > x);
      d2_en    = req_final_sample && (count_ff != '0) && in_range;
      d2_lt    = (x < newer_ff);
      d2_gt    = (x > newer_ff);
      min_inc  = (d1_en && d1_lt) || (d2_en && d2_lt);
      max_inc  = (d1_en && !d1_lt && d1_gt) || (d2_en && !d2_lt && d2_gt);
      minima_in = (min_inc && (minima_ff != TOTAL_MAX)) ? minima_ff + 1'b1 : minima_ff;
      maxima_in = (max_inc && (maxima_ff != TOTAL_MAX)) ? maxima_ff + 1'b1 : maxima_ff;
      overflow_in = overflow_ff || !in_range;
   end

   // assemble this item's results in position order
   always_comb begin
      push_data = '0;
      slot      = '0;
      if (d1_en && (d1_lt || d1_gt)) begin
         push_data[slot].kind     = d1_lt ? KIND_MIN : KIND_MAX;
         push_data[slot].position = POS_WIDTH'(count_ff - COUNT_WIDTH'(1));
         slot = slot + 1'b1;
      end
      if (d2_en && (d2_lt || d2_gt)) begin
         push_data[slot].kind     = d2_lt ? KIND_MIN : KIND_MAX;
         push_data[slot].position = POS_WIDTH'(count_ff);
         slot = slot + 1'b1;
      end
      if (req_final_sample) begin
         push_data[slot].kind         = KIND_SUMMARY;
         push_data[slot].minima_total = minima_in;
         push_data[slot].maxima_total = maxima_in;
         push_data[slot].too_long     = overflow_in;
         slot = slot + 1'b1;
      end
      if (slot != '0) begin
         push_data[slot - 1'b1].last_of_run = 1'b1;
      end
      if (!accept) begin
         slot = '0;
      end
   end

   // next window and counts; a final sample starts a fresh array
   always_comb begin
      older_in = older_ff;
      newer_in = newer_ff;
      count_in = count_ff;
      if (in_range) begin
         older_in = newer_ff;
         newer_in = x;
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff    <= '0;
         newer_ff    <= '0;
         count_ff    <= '0;
         minima_ff   <= '0;
         maxima_ff   <= '0;
         overflow_ff <= 1'b0;
      end else if (accept) begin
         if (req_final_sample) begin
            older_ff    <= '0;
            newer_ff    <= '0;
            count_ff    <= '0;
            minima_ff   <= '0;
            maxima_ff   <= '0;
            overflow_ff <= 1'b0;
         end else begin
            older_ff    <= older_in;
            newer_ff    <= newer_in;
            count_ff    <= count_in;
            minima_ff   <= minima_in;
            maxima_ff   <= maxima_in;
            overflow_ff <= overflow_in;
         end
      end
   end

   // hold results until the receiver takes them
   led_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (slot),
      .push_data  (push_data),
      .status     (q_status),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_data   (head)
   );

   assign rsp_kind         = head.kind;
   assign rsp_position     = head.position;
   assign rsp_minima_total = head.minima_total;
   assign rsp_maxima_total = head.maxima_total;
   assign rsp_too_long     = head.too_long;
   assign rsp_last_of_run  = head.last_of_run;

   // checks
   `LED_ASSERT_NOW(a_final_has_summary, clock, reset, accept && req_final_sample,
      slot != '0 && push_data[slot - 1'b1].kind == KIND_SUMMARY,
      "final item did not queue a summary result")
   `LED_ASSERT_NEXT(a_final_clears, clock, reset, accept && req_final_sample,
      count_ff == '0 && minima_ff == '0 && maxima_ff == '0 && !overflow_ff,
      "state not cleared after final item")
   `LED_ASSERT_NEXT(a_count_advance, clock, reset,
      accept && !req_final_sample && in_range,
      count_ff == $past(count_ff) + 1'b1, "sample count did not advance")
   `LED_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1,
      q_status.level <= LEVEL_WIDTH'(QUEUE_DEPTH), "result queue over depth")

endmodule

// File: test/local_extrema_checker.sv
// Scoreboard for the local extrema detector: watches both channels, predicts each item's
// results from its own copy of the window and counts, and compares every result field.
// Depends on led_pkg.
module local_extrema_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_sample,
   input  logic        req_final_sample,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_kind,
   input  logic [15:0] rsp_position,
   input  logic [16:0] rsp_minima_total,
   input  logic [16:0] rsp_maxima_total,
   input  logic        rsp_too_long,
   input  logic        rsp_last_of_run,
   output int          failures,
   output int          pending,
   output int          samples_seen,
   output int          arrays_seen,
   output int          results_seen
);
   import led_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   // window and counts of the array in progress
   logic signed [SAMPLE_WIDTH-1:0] older_value;
   logic signed [SAMPLE_WIDTH-1:0] newer_value;
   int                             sample_total;
   logic [TOTAL_WIDTH-1:0]         minima_count;
   logic [TOTAL_WIDTH-1:0]         maxima_count;
   logic                           overflow_seen;

   result_type expected_results[$];
   int         error_count = 0;
   int         sample_tally = 0;
   int         array_tally = 0;
   int         result_tally = 0;

   task automatic clear_window();
      older_value   = '0;
      newer_value   = '0;
      sample_total  = 0;
      minima_count  = '0;
      maxima_count  = '0;
      overflow_seen = 1'b0;
   endtask

   // Queue an extremum at pos if it has a neighbour and centre is strictly beyond each one.
   task automatic judge_position(input int pos,
                                 input logic signed [SAMPLE_WIDTH-1:0] centre,
                                 input bit has_left,
                                 input logic signed [SAMPLE_WIDTH-1:0] left,
                                 input bit has_right,
                                 input logic signed [SAMPLE_WIDTH-1:0] right);
      bit         lower;
      bit         higher;
      result_type found;
      lower  = (!has_left || centre < left) && (!has_right || centre < right);
      higher = (!has_left || centre > left) && (!has_right || centre > right);
      found = '0;
      found.position = pos[POS_WIDTH-1:0];
      if (!has_left && !has_right) begin
         return;
      end
      if (lower) begin
         found.kind = KIND_MIN;
         expected_results.push_back(found);
         if (minima_count != TOTAL_MAX) minima_count++;
      end else if (higher) begin
         found.kind = KIND_MAX;
         expected_results.push_back(found);
         if (maxima_count != TOTAL_MAX) maxima_count++;
      end
   endtask

   // Advance the window by one sample and queue the results it decides.
   task automatic predict_sample(input logic signed [SAMPLE_WIDTH-1:0] x, input logic fin);
      int         n;
      int         start;
      result_type tail;
      n = sample_total;
      start = expected_results.size();
      if (n < MAX_LEN) begin
         if (n >= 1) judge_position(n - 1, newer_value, n >= 2, older_value, 1'b1, x);
         if (fin && n >= 1) judge_position(n, x, 1'b1, newer_value, 1'b0, '0);
         older_value  = newer_value;
         newer_value  = x;
         sample_total = n + 1;
      end else begin
         // past the limit: only the first extra sample closes the last position
         if (!overflow_seen) judge_position(n - 1, newer_value, n >= 2, older_value, 1'b1, x);
         overflow_seen = 1'b1;
      end
      if (fin) begin
         tail = '0;
         tail.kind         = KIND_SUMMARY;
         tail.minima_total = minima_count;
         tail.maxima_total = maxima_count;
         tail.too_long     = overflow_seen;
         expected_results.push_back(tail);
         clear_window();
      end
      // mark the last result of this item
      if (expected_results.size() > start) begin
         tail = expected_results.pop_back();
         tail.last_of_run = 1'b1;
         expected_results.push_back(tail);
      end
   endtask

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         if (error_count < REPORT_LIMIT) begin
            $display("%0t result %0d: %s expected %0d, got %0d",
                     $realtime, result_tally, field, want, got);
         end
         error_count++;
      end
   endtask

   initial clear_window();

   always @(posedge clock) begin : watch_channels
      result_type want;
      if (reset) begin
         expected_results.delete();
         clear_window();
      end else begin
         // compare the result leaving this cycle with the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               if (error_count < REPORT_LIMIT) begin
                  $display("%0t unexpected result: kind %0d position %0d",
                           $realtime, rsp_kind, rsp_position);
               end
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("kind", int'(want.kind), int'(rsp_kind));
               check_field("position", int'(want.position), int'(rsp_position));
               check_field("minima_total", int'(want.minima_total), int'(rsp_minima_total));
               check_field("maxima_total", int'(want.maxima_total), int'(rsp_maxima_total));
               check_field("too_long", int'(want.too_long), int'(rsp_too_long));
               check_field("last_of_run", int'(want.last_of_run), int'(rsp_last_of_run));
            end
            result_tally++;
         end
         // predict from the item accepted this cycle
         if (req_valid && req_ready) begin
            predict_sample(req_sample[SAMPLE_WIDTH-1:0], req_final_sample);
            sample_tally++;
            if (req_final_sample) array_tally++;
         end
      end
      failures     <= error_count;
      pending      <= expected_results.size();
      samples_seen <= sample_tally;
      arrays_seen  <= array_tally;
      results_seen <= result_tally;
   end

endmodule

// File: test/local_extrema_detector_tb.sv
// Top of the local extrema detector testbench: clock, reset, sample stimulus and verdict.
// Depends on local_extrema_detector and local_extrema_checker.
module local_extrema_detector_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CYCLE_LIMIT  = 1_000_000;
   localparam int          DRAIN_CYCLES = 8;
   localparam logic [31:0] SAMPLE_LOW   = 32'h8000_0000;
   localparam logic [31:0] SAMPLE_HIGH  = 32'h7FFF_FFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_sample = '0;
   logic        req_final_sample = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [15:0] rsp_position;
   logic [16:0] rsp_minima_total;
   logic [16:0] rsp_maxima_total;
   logic        rsp_too_long;
   logic        rsp_last_of_run;

   int failures;
   int pending;
   int samples_seen;
   int arrays_seen;
   int results_seen;
   int send_idle = 0;
   int recv_stall = 0;
   int cycle_count = 0;

   local_extrema_detector i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .req_final_sample (req_final_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_position     (rsp_position),
      .rsp_minima_total (rsp_minima_total),
      .rsp_maxima_total (rsp_maxima_total),
      .rsp_too_long     (rsp_too_long),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   local_extrema_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .req_final_sample (req_final_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_position     (rsp_position),
      .rsp_minima_total (rsp_minima_total),
      .rsp_maxima_total (rsp_maxima_total),
      .rsp_too_long     (rsp_too_long),
      .rsp_last_of_run  (rsp_last_of_run),
      .failures         (failures),
      .pending          (pending),
      .samples_seen     (samples_seen),
      .arrays_seen      (arrays_seen),
      .results_seen     (results_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stall the result channel at the current rate
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall);
   end

   // stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("local_extrema_detector_tb: errors");
         $finish;
      end
   end

   // Mix full-range values, extremes and a narrow band that yields equal neighbours.
   function automatic logic [31:0] pick_sample();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($urandom_range(6)) - 32'd3;
         2: begin
            case ($urandom_range(3))
               0: return SAMPLE_LOW;
               1: return SAMPLE_HIGH;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return 32'($urandom_range(15));
      endcase
   endfunction

   // Offer one item after a random idle stretch and hold it until accepted.
   task automatic send_sample(input logic [31:0] value, input logic fin);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         req_sample <= $urandom;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_sample       <= value;
      req_final_sample <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_array(input int length);
      for (int i = 0; i < length; i++) begin
         send_sample(pick_sample(), i == length - 1);
      end
   endtask

   // Send whole arrays, mostly short, until the phase has its share of items.
   task automatic run_phase(input int idle_pct, input int stall_pct, input int items);
      int sent;
      int length;
      sent = 0;
      send_idle  = idle_pct;
      recv_stall = stall_pct;
      while (sent < items) begin
         length = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(6, 1);
         send_array(length);
         sent += length;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-element arrays: summary only
      send_sample(SAMPLE_HIGH, 1'b1);
      send_sample(SAMPLE_LOW, 1'b1);
      // two elements: each end against its one neighbour
      send_sample(SAMPLE_LOW, 1'b0);
      send_sample(SAMPLE_HIGH, 1'b1);
      // equal pair gives no extremum, only the summary
      send_sample(32'd5, 1'b0);
      send_sample(32'd5, 1'b1);
      // alternating extremes
      send_sample(SAMPLE_HIGH, 1'b0);
      send_sample(SAMPLE_LOW, 1'b0);
      send_sample(SAMPLE_HIGH, 1'b0);
      send_sample(SAMPLE_LOW, 1'b1);
      // plateaus on both sides
      send_sample(32'd1, 1'b0);
      send_sample(32'd3, 1'b0);
      send_sample(32'd3, 1'b0);
      send_sample(32'd1, 1'b0);
      send_sample('1, 1'b0);
      send_sample('1, 1'b0);
      send_sample(32'd2, 1'b1);
      // monotonic ramp
      send_sample(32'd1, 1'b0);
      send_sample(32'd2, 1'b0);
      send_sample(32'd3, 1'b1);

      run_phase(0, 0, 25);
      run_phase(83, 0, 25);
      run_phase(0, 83, 25);
      run_phase(28, 28, 25);

      // drain the results still expected
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d samples over %0d arrays and %0d results,", samples_seen,
               arrays_seen, results_seen);
      $display("with directed edge arrays and four idle and stall mixes");
      if (failures == 0) begin
         $display("local_extrema_detector_tb: clean");
      end else begin
         $display("local_extrema_detector_tb: errors");
      end
      $finish;
   end

endmodule

// File: local_extrema_detector.f
+incdir+design
design/led_pkg.sv
design/led_queue.sv
design/local_extrema_detector.sv
test/local_extrema_checker.sv
test/local_extrema_detector_tb.sv
